@@ hw/rtl/savgol_padded_fir_filter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Savitzky-Golay padded FIR core: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SAVGOL_PADDED_FIR_FILTER_CORE_DEFINES_SVH
`define SAVGOL_PADDED_FIR_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is asserted
`define SGF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds across reset
`define SGF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SGF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hw/rtl/sgf_pkg.sv @@
// ----------------------------------------------------------------------------
// Savitzky-Golay padded FIR core: package
// Field widths, function codes, register indexes and padding modes.
// ----------------------------------------------------------------------------
package sgf_pkg;

  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 18;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int HALF_W   = 8;
  localparam int PAD_W    = 2;
  localparam int LEN_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int FRAC_W   = 15;

  localparam logic [FUNC_W-1:0] FN_LOAD_COEF   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_SAMPLE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_COMPUTE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LENGTH = 2'd2;

  localparam logic [PAD_W-1:0] PAD_REFLECT = 2'd0;
  localparam logic [PAD_W-1:0] PAD_NEAREST = 2'd1;
  localparam logic [PAD_W-1:0] PAD_WRAP    = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_WINDOW = 1'b1;

endpackage

@@ hw/rtl/sgf_if.sv @@
// ----------------------------------------------------------------------------
// Savitzky-Golay padded FIR core: stream interfaces
// Request word (load or compute) and result word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgf_req_if;
  import sgf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [INDEX_W-1:0]         index;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

interface sgf_res_if;
  import sgf_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [INDEX_W-1:0]          position;
  logic signed [SAMPLE_W-1:0]  filtered_value;
  logic                        saturated;
  logic                        status;

  modport source (output valid, position, filtered_value, saturated, status, input ready);
  modport sink   (input valid, position, filtered_value, saturated, status, output ready);
endinterface

@@ hw/rtl/savgol_padded_fir_filter_core.sv @@
// ----------------------------------------------------------------------------
// Savitzky-Golay padded FIR core
// Sample and coefficient memories with a one-tap-per-cycle MAC sequencer.
// ----------------------------------------------------------------------------
// Load words (coefficient or sample) are written to memory when accepted.
// A compute word reads one tap per cycle from the sample and coefficient
// memories, 2*half_window+1 taps in all, then passes through memory read,
// multiply, accumulate and round. A compute word with a window error skips
// the MAC loop and goes straight to the finish state. A new word is taken
// once the previous one has left the sequencer; a finished result waits in the
// output register without blocking loads. Memories hold no reset value and
// need no clearing pass.
`include "savgol_padded_fir_filter_core_defines.svh"

module savgol_padded_fir_filter_core #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_TAPS    = 257
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sgf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sgf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  sgf_req_if.sink                          in_if,
  sgf_res_if.source                        out_if
);
  import sgf_pkg::*;

  localparam int SAW   = $clog2(MAX_SAMPLES);
  localparam int CAW   = $clog2(MAX_TAPS);
  localparam int LW    = ($clog2(MAX_SAMPLES + 1) > LEN_W) ? $clog2(MAX_SAMPLES + 1) : LEN_W;
  localparam int PW    = LW + 2;
  localparam int ACC_W = PROD_W + CAW + 1;
  localparam int TW    = HALF_W + 1;

  localparam logic signed [ACC_W-1:0] ROUND_OFS = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] RES_MAX   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] RES_MIN   = -ACC_W'(32768);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // configuration
  logic [HALF_W-1:0] half_window_q;
  logic [PAD_W-1:0]  pad_mode_q;
  logic [LEN_W-1:0]  signal_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q   <= '0;
      pad_mode_q      <= PAD_REFLECT;
      signal_length_q <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_WINDOW:   half_window_q   <= cfg_data_i[HALF_W-1:0];
        CFG_PAD_MODE:      pad_mode_q      <= cfg_data_i[PAD_W-1:0];
        CFG_SIGNAL_LENGTH: signal_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e                    state_q;
  logic [CAW-1:0]            k_q;
  logic signed [PW-1:0]      j_q;
  logic                      rd_v_q;
  logic                      mul_v_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [INDEX_W-1:0]        pos_q;
  logic                      status_q;

  logic                      out_valid_q;
  logic [INDEX_W-1:0]        out_pos_q;
  logic signed [SAMPLE_W-1:0] out_val_q;
  logic                      out_sat_q;
  logic                      out_status_q;

  // derived values
  logic [LW-1:0]         n_w;
  logic [TW-1:0]         taps_w;
  logic                  err_w;
  logic                  in_acc_w;
  logic                  rd_en_w;
  logic                  last_tap_w;
  logic signed [PW-1:0]  n_s;
  logic signed [PW-1:0]  s_w;
  logic [SAW-1:0]        s_addr_w;
  logic signed [ACC_W-1:0] rnd_w;
  logic signed [ACC_W-1:0] res_w;
  logic                  out_free_w;
  logic signed [SAMPLE_W-1:0] smp_sat_w;

  assign n_w = (LW'(signal_length_q) > LW'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES)
                                                           : LW'(signal_length_q);
  assign taps_w = TW'({half_window_q, 1'b0}) + TW'(1);
  assign err_w  = (LW'(taps_w) > n_w) || (32'(taps_w) > MAX_TAPS) ||
                  (LW'(in_if.index) >= n_w);

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc_w    = in_if.valid && in_if.ready;
  assign rd_en_w     = (state_q == ST_RUN);
  assign last_tap_w  = (32'(k_q) == 32'({half_window_q, 1'b0}));
  assign n_s         = $signed(PW'(n_w));

  // padded sample address
  always_comb begin
    s_w = j_q;
    if (j_q < 0) begin
      case (pad_mode_q)
        PAD_REFLECT: s_w = -j_q;
        PAD_WRAP:    s_w = j_q + n_s;
        default:     s_w = '0;
      endcase
    end else if (j_q >= n_s) begin
      case (pad_mode_q)
        PAD_REFLECT: s_w = (n_s <<< 1) - PW'(2) - j_q;
        PAD_WRAP:    s_w = j_q - n_s;
        default:     s_w = n_s - PW'(1);
      endcase
    end
  end
  assign s_addr_w = SAW'(s_w);

  always_comb begin
    if (in_if.value > $signed(VALUE_W'(32767))) begin
      smp_sat_w = SAMPLE_W'(32767);
    end else if (in_if.value < -$signed(VALUE_W'(32768))) begin
      smp_sat_w = -SAMPLE_W'(32768);
    end else begin
      smp_sat_w = SAMPLE_W'(in_if.value);
    end
  end

  // memories
  logic [SAMPLE_W-1:0]        smp_mem [MAX_SAMPLES];
  logic [COEF_W-1:0]          coef_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] smp_rd_q;
  logic signed [COEF_W-1:0]   coef_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc_w && in_if.func == FN_LOAD_SAMPLE && 32'(in_if.index) < MAX_SAMPLES) begin
      smp_mem[SAW'(in_if.index)] <= smp_sat_w;
    end
    if (rd_en_w) begin
      smp_rd_q <= smp_mem[s_addr_w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_w && in_if.func == FN_LOAD_COEF && 32'(in_if.index) < MAX_TAPS) begin
      coef_mem[CAW'(in_if.index)] <= in_if.value;
    end
    if (rd_en_w) begin
      coef_rd_q <= coef_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= smp_rd_q * coef_rd_q;
    end
  end

  // round half up, saturate
  assign rnd_w = acc_q + ROUND_OFS;
  assign res_w = rnd_w >>> FRAC_W;
  assign out_free_w = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      j_q          <= '0;
      rd_v_q       <= 1'b0;
      mul_v_q      <= 1'b0;
      acc_q        <= '0;
      pos_q        <= '0;
      status_q     <= STATUS_OK;
      out_valid_q  <= 1'b0;
      out_pos_q    <= '0;
      out_val_q    <= '0;
      out_sat_q    <= 1'b0;
      out_status_q <= STATUS_OK;
    end else begin
      rd_v_q  <= rd_en_w;
      mul_v_q <= rd_v_q;
      if (mul_v_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc_w && in_if.func == FN_COMPUTE) begin
            pos_q <= in_if.index;
            acc_q <= '0;
            k_q   <= '0;
            j_q   <= $signed(PW'(in_if.index)) - $signed(PW'(half_window_q));
            if (err_w) begin
              status_q <= STATUS_WINDOW;
              state_q  <= ST_FINISH;
            end else begin
              status_q <= STATUS_OK;
              state_q  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          k_q <= k_q + CAW'(1);
          j_q <= j_q + PW'(1);
          if (last_tap_w) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_q && !mul_v_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free_w) begin
            out_valid_q  <= 1'b1;
            out_pos_q    <= pos_q;
            out_status_q <= status_q;
            if (res_w > RES_MAX) begin
              out_val_q <= SAMPLE_W'(32767);
              out_sat_q <= 1'b1;
            end else if (res_w < RES_MIN) begin
              out_val_q <= -SAMPLE_W'(32768);
              out_sat_q <= 1'b1;
            end else begin
              out_val_q <= SAMPLE_W'(res_w);
              out_sat_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.position       = out_pos_q;
  assign out_if.filtered_value = out_val_q;
  assign out_if.saturated      = out_sat_q;
  assign out_if.status         = out_status_q;

  // checks
  `SGF_ASSERT(a_idle_pipe_empty, clk_i, rst_ni, in_if.ready |-> (!rd_v_q && !mul_v_q), "word taken with MAC pipeline busy")
  `SGF_ASSERT(a_err_result_zero, clk_i, rst_ni, (out_if.valid && out_if.status == STATUS_WINDOW) |-> (out_if.filtered_value == 0 && !out_if.saturated), "error result not cleared")
  `SGF_ASSERT(a_err_skips_mac, clk_i, rst_ni, (in_acc_w && in_if.func == FN_COMPUTE && err_w) |=> (state_q == ST_FINISH), "window error entered MAC loop")
  `SGF_ASSERT_ALWAYS(a_reset_no_result, clk_i, (!rst_ni) |=> !out_if.valid, "result shown after reset")

endmodule

@@ tb/savgol_padded_fir_filter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Savitzky-Golay padded FIR core: testbench
// Loads coefficient and sample words, then asks for filtered outputs under
// several window, padding and length settings. A scoreboard keeps its own
// copy of both memories and the registers. It works out each result word from
// that copy and checks the words that come out against it, in order. Both
// ends of the stream idle at random, and the result side once holds off long
// enough to stall the request side.
// ----------------------------------------------------------------------------
module savgol_padded_fir_filter_core_tb;
  import sgf_pkg::*;

  localparam int MEM_SAMPLES  = 1024;
  localparam int MEM_TAPS     = 257;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [FUNC_W-1:0] FN_UNUSED  = 2'd3;
  localparam logic [PAD_W-1:0]  PAD_UNUSED = 2'd3;

  typedef struct packed {
    logic [INDEX_W-1:0]         position;
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       saturated;
    logic                       status;
  } result_t;

  class filter_scoreboard;
    logic signed [SAMPLE_W-1:0] sample_mem [MEM_SAMPLES];
    logic signed [COEF_W-1:0]   coef_mem [MEM_TAPS];
    bit                         sample_written [MEM_SAMPLES];
    bit                         coef_written [MEM_TAPS];
    logic [HALF_W-1:0]          half_window;
    logic [PAD_W-1:0]           pad_mode;
    logic [LEN_W-1:0]           signal_length;
    result_t                    expected_q [$];
    int                         errors;

    function new();
      half_window   = '0;
      pad_mode      = PAD_REFLECT;
      signal_length = LEN_W'(1);
      errors        = 0;
      foreach (sample_written[i]) sample_written[i] = 1'b0;
      foreach (coef_written[i]) coef_written[i] = 1'b0;
    endfunction

    function int eff_len();
      return (signal_length > MEM_SAMPLES) ? MEM_SAMPLES : int'(signal_length);
    endfunction

    function int taps();
      return 2 * int'(half_window) + 1;
    endfunction

    function bit window_error(int pos);
      return taps() > eff_len() || taps() > MEM_TAPS || pos >= eff_len();
    endfunction

    // sample address behind tap k of the window centred on pos
    function int sample_src(int pos, int k);
      int n;
      int j;
      int s;
      n = eff_len();
      j = pos + k - int'(half_window);
      if (j >= 0 && j < n) s = j;
      else if (pad_mode == PAD_REFLECT) s = (j < 0) ? -j : 2 * n - 2 - j;
      else if (pad_mode == PAD_WRAP) s = (j < 0) ? j + n : j - n;
      else s = (j < 0) ? 0 : n - 1;
      if (s < 0) s = 0;
      if (s >= n) s = n - 1;
      return s;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_HALF_WINDOW:   half_window = data[HALF_W-1:0];
        CFG_PAD_MODE:      pad_mode = data[PAD_W-1:0];
        CFG_SIGNAL_LENGTH: signal_length = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                               logic signed [VALUE_W-1:0] value);
      result_t r;
      longint  acc;
      longint  rounded;
      int      pos;
      int      k;
      pos = int'(idx);
      case (func)
        FN_LOAD_COEF: begin
          if (pos < MEM_TAPS) begin
            coef_mem[pos]     = value;
            coef_written[pos] = 1'b1;
          end
        end
        FN_LOAD_SAMPLE: begin
          if (value > 32767) sample_mem[pos] = 16'sh7fff;
          else if (value < -32768) sample_mem[pos] = -16'sh8000;
          else sample_mem[pos] = value[SAMPLE_W-1:0];
          sample_written[pos] = 1'b1;
        end
        FN_COMPUTE: begin
          r.position       = idx;
          r.filtered_value = '0;
          r.saturated      = 1'b0;
          r.status         = STATUS_OK;
          if (window_error(pos)) begin
            r.status = STATUS_WINDOW;
          end else begin
            acc = 0;
            for (k = 0; k < taps(); k++)
              acc += longint'(coef_mem[k]) * longint'(sample_mem[sample_src(pos, k)]);
            rounded = (acc + 64'sd16384) >>> FRAC_W;
            if (rounded > 32767) begin
              rounded     = 32767;
              r.saturated = 1'b1;
            end else if (rounded < -32768) begin
              rounded     = -32768;
              r.saturated = 1'b1;
            end
            r.filtered_value = rounded[SAMPLE_W-1:0];
          end
          expected_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result word at position %0d", got.position);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, got.position);
        errors++;
      end
      if (got.filtered_value !== want.filtered_value) begin
        $error("filtered_value: expected %0d, actual %0d",
               want.filtered_value, got.filtered_value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sgf_req_if req_if ();
  sgf_res_if res_if ();

  filter_scoreboard sb = new();

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          rx_hold_req;
  int unsigned cycle_count;

  savgol_padded_fir_filter_core #(
    .MAX_SAMPLES(MEM_SAMPLES),
    .MAX_TAPS   (MEM_TAPS)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (req_if),
    .out_if    (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_sink
    result_t got;
    int      hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.position       = res_if.position;
        got.filtered_value = res_if.filtered_value;
        got.saturated      = res_if.saturated;
        got.status         = res_if.status;
        sb.check_result(got);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= func;
    req_if.index <= idx;
    req_if.value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(func, idx, value);
  endtask

  // let every result word out, then allow for a compute still in the sequencer
  task automatic drain_block();
    req_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int half, input logic [PAD_W-1:0] pad, input int len);
    drain_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_HALF_WINDOW;
    cfg_data_i <= CFG_DATA_W'(half);
    @(posedge clk_i);
    sb.set_reg(CFG_HALF_WINDOW, CFG_DATA_W'(half));
    cfg_idx_i  <= CFG_PAD_MODE;
    cfg_data_i <= CFG_DATA_W'(pad);
    @(posedge clk_i);
    sb.set_reg(CFG_PAD_MODE, CFG_DATA_W'(pad));
    cfg_idx_i  <= CFG_SIGNAL_LENGTH;
    cfg_data_i <= CFG_DATA_W'(len);
    @(posedge clk_i);
    sb.set_reg(CFG_SIGNAL_LENGTH, CFG_DATA_W'(len));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [VALUE_W-1:0] coef_pick();
    int m;
    m = 24000 / sb.taps() + 1;
    case ($urandom_range(0, 7))
      0:       return VALUE_W'($urandom());
      1:       return $urandom_range(0, 1) ? VALUE_W'(131071) : VALUE_W'(-131072);
      default: return VALUE_W'(int'($urandom_range(0, 2 * m)) - m);
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] sample_pick();
    case ($urandom_range(0, 15))
      0:       return VALUE_W'($urandom());
      1:       return $urandom_range(0, 1) ? VALUE_W'(32767) : VALUE_W'(-32768);
      default: return VALUE_W'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // write every tap and sample the window at pos reads, where still unwritten
  task automatic fill_window(input int pos);
    int k;
    int s;
    for (k = 0; k < sb.taps(); k++) begin
      if (!sb.coef_written[k]) send_word(FN_LOAD_COEF, INDEX_W'(k), coef_pick());
      s = sb.sample_src(pos, k);
      if (!sb.sample_written[s]) send_word(FN_LOAD_SAMPLE, INDEX_W'(s), sample_pick());
    end
  endtask

  task automatic run_phase(input int half, input logic [PAD_W-1:0] pad, input int len,
                           input int n_words, input bit hold);
    int counted;
    int sel;
    int pos;
    int n;
    int reach;
    configure(half, pad, len);
    if (hold) rx_hold_req = 1'b1;
    counted = 0;
    n = sb.eff_len();
    while (counted < n_words) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        reach = (half < n - 1) ? half : n - 1;
        case ($urandom_range(0, 9))
          0, 1:    pos = $urandom_range(0, MEM_SAMPLES - 1);
          2, 3, 4: pos = $urandom_range(0, 1) ? $urandom_range(0, reach)
                                             : n - 1 - int'($urandom_range(0, reach));
          default: pos = $urandom_range(0, n - 1);
        endcase
        if (n == 0) pos = $urandom_range(0, MEM_SAMPLES - 1);
        if (!sb.window_error(pos)) fill_window(pos);
        send_word(FN_COMPUTE, INDEX_W'(pos), VALUE_W'($urandom()));
        counted++;
      end else if (sel < 65) begin
        if ($urandom_range(0, 99) < 85) begin
          pos = $urandom_range(0, sb.taps() - 1);
          if (pos >= MEM_TAPS) pos = MEM_TAPS - 1;
        end else begin
          pos = $urandom_range(0, MEM_SAMPLES - 1);
        end
        send_word(FN_LOAD_COEF, INDEX_W'(pos), coef_pick());
        if (pos < MEM_TAPS) counted++;
      end else if (sel < 92) begin
        if (n > 0 && $urandom_range(0, 99) < 80) pos = $urandom_range(0, n - 1);
        else pos = $urandom_range(0, MEM_SAMPLES - 1);
        send_word(FN_LOAD_SAMPLE, INDEX_W'(pos), sample_pick());
        counted++;
      end else begin
        send_word(FN_UNUSED, INDEX_W'($urandom()), VALUE_W'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    tx_idle_pct = 22;
    rx_idle_pct = 58;
    rx_hold_req = 1'b0;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_HALF_WINDOW;
    cfg_data_i   <= '0;
    req_if.valid <= 1'b0;
    req_if.func  <= FN_LOAD_COEF;
    req_if.index <= '0;
    req_if.value <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single tap over a one-sample signal: saturation both ways, rounding
    send_word(FN_LOAD_COEF, 10'd0, 18'sd131071);
    send_word(FN_LOAD_SAMPLE, 10'd0, 18'sd32767);
    send_word(FN_COMPUTE, 10'd0, 18'sd0);
    send_word(FN_COMPUTE, 10'd1023, 18'sd0);
    send_word(FN_UNUSED, 10'd1023, -18'sd1);
    send_word(FN_LOAD_SAMPLE, 10'd1023, -18'sd131072);
    send_word(FN_LOAD_COEF, 10'd1023, 18'sd131071);
    send_word(FN_LOAD_COEF, 10'd0, -18'sd131072);
    send_word(FN_COMPUTE, 10'd0, 18'sd131071);
    send_word(FN_LOAD_SAMPLE, 10'd0, -18'sd131072);
    send_word(FN_COMPUTE, 10'd0, -18'sd131072);
    send_word(FN_LOAD_SAMPLE, 10'd0, 18'sd131071);
    send_word(FN_LOAD_COEF, 10'd0, 18'sd32768);
    send_word(FN_COMPUTE, 10'd0, 18'sd0);
    send_word(FN_LOAD_COEF, 10'd0, 18'sd1);
    send_word(FN_LOAD_SAMPLE, 10'd0, 18'sd16384);
    send_word(FN_COMPUTE, 10'd0, 18'sd0);
    send_word(FN_LOAD_COEF, 10'd0, -18'sd1);
    send_word(FN_COMPUTE, 10'd0, 18'sd0);
    send_word(FN_LOAD_COEF, 10'd0, 18'sd32768);
    // length past the memory, too many taps, window over length, zero length
    configure(0, PAD_WRAP, 2047);
    send_word(FN_COMPUTE, 10'd1023, 18'sd0);
    configure(255, PAD_NEAREST, 1024);
    send_word(FN_COMPUTE, 10'd5, 18'sd0);
    configure(128, PAD_REFLECT, 256);
    send_word(FN_COMPUTE, 10'd0, 18'sd0);
    configure(0, PAD_UNUSED, 0);
    send_word(FN_COMPUTE, 10'd0, 18'sd0);

    run_phase(2, PAD_REFLECT, 16, 120, 1'b0);
    run_phase(0, PAD_NEAREST, 1, 40, 1'b0);
    run_phase(3, PAD_WRAP, 7, 120, 1'b0);
    run_phase(128, PAD_REFLECT, 257, 40, 1'b0);

    tx_idle_pct = 58;
    rx_idle_pct = 22;
    run_phase(1, PAD_UNUSED, 5, 150, 1'b1);
    run_phase(2, PAD_WRAP, 2047, 100, 1'b0);
    run_phase(8, PAD_REFLECT, 40, 120, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(4, PAD_NEAREST, 9, 120, 1'b0);
    run_phase(6, PAD_WRAP, 13, 120, 1'b0);
    run_phase(20, PAD_NEAREST, 100, 80, 1'b0);

    drain_block();
    if (sb.expected_q.size() != 0) begin
      $error("%0d result words never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
